// ----- hdl/arfp_pkg.sv -----
// Shared types and constants for the AArch64 relocation field patcher.
`default_nettype none

package arfp_pkg;

    // Operation requested for one beat.
    typedef enum logic [1:0] {
        KIND_DECODE = 2'd0,
        KIND_ADRP   = 2'd1,
        KIND_B26    = 2'd2,
        KIND_IMM12  = 2'd3
    } kind_t;

    // Instruction class reported by the decoder.
    typedef enum logic [1:0] {
        CLS_NONE  = 2'd0,
        CLS_ADRP  = 2'd1,
        CLS_B26   = 2'd2,
        CLS_IMM12 = 2'd3
    } class_t;

    // Access kind of an imm12 form.
    localparam logic [1:0] ACC_ADD   = 2'd0;
    localparam logic [1:0] ACC_LOAD  = 2'd1;
    localparam logic [1:0] ACC_STORE = 2'd2;

    // Opcode masks and match patterns.
    localparam logic [31:0] ADRP_MASK   = 32'h9F00_0000;
    localparam logic [31:0] ADRP_MATCH  = 32'h9000_0000;
    localparam logic [31:0] B26_MASK    = 32'h7C00_0000;
    localparam logic [31:0] B26_MATCH   = 32'h1400_0000;
    localparam logic [31:0] LDST_MASK   = 32'h3B00_0000;
    localparam logic [31:0] LDST_MATCH  = 32'h3900_0000;
    localparam logic [31:0] ADDI_MASK   = 32'h7FC0_0000;
    localparam logic [31:0] ADDI_MATCH  = 32'h1100_0000;

    // Decoded view of one instruction word.
    typedef struct packed {
        class_t             cls;
        logic [4:0]         dst;
        logic [4:0]         src;
        logic signed [27:0] offset;
        logic [1:0]         access;
        logic [4:0]         scale;
        logic               sext;
        logic               fp;
    } decoded_t;

endpackage

`default_nettype wire

// ----- hdl/arm64_reloc_field_patcher.sv -----
// Top level: AArch64 instruction decoder and relocation field patcher.
// An accepted start beat passes through the input registers, then the result registers, which raise done.
// Throughput: one beat per cycle; busy is always low, since the decode and
// the two address subtractions fit between the input and result registers.
// Reset clears only the stage valid flags; no results are pending after it.
// The result stands for exactly one cycle with done high.
`default_nettype none

module arm64_reloc_field_patcher (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic [1:0]         kind,
    input  wire logic [31:0]        instruction,
    input  wire logic [63:0]        instr_addr,
    input  wire logic [63:0]        target_addr,
    input  wire logic [11:0]        new_imm12,
    output logic                    done,
    output logic                    ok,
    output logic [31:0]             new_instruction,
    output logic [1:0]              match_class,
    output logic [4:0]              dst_reg,
    output logic [4:0]              src_reg,
    output logic signed [27:0]      offset,
    output logic [1:0]              access_kind,
    output logic [4:0]              scale,
    output logic                    sign_extend,
    output logic                    is_float
);

    // Input stage registers.
    logic           in_valid_reg;
    logic [1:0]     kind_reg;
    logic [31:0]    instr_reg;
    logic [63:0]    ia_reg;
    logic [63:0]    ta_reg;
    logic [11:0]    imm_reg;

    // Result stage registers.
    logic                   done_reg;
    logic                   ok_reg;
    logic [31:0]            nw_reg;
    arfp_pkg::decoded_t     dec_reg;

    // Combinational results.
    arfp_pkg::decoded_t     dec_next;
    logic                   ok_next;
    logic [31:0]            nw_next;
    logic [2:0]             ls_shift;
    logic [1:0]             ls_access;
    logic                   ls_sext;
    logic                   ls_valid;
    logic [51:0]            page_delta;
    logic [63:0]            byte_delta;
    logic                   adrp_in_range;
    logic                   b26_in_range;

    assign busy = 1'b0;

    // Valid flags for both stages.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            in_valid_reg <= start;
            done_reg     <= in_valid_reg;
        end
    end

    // Payload capture; a beat enters on every cycle that start is high.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            kind_reg  <= kind;
            instr_reg <= instruction;
            ia_reg    <= instr_addr;
            ta_reg    <= target_addr;
            imm_reg   <= new_imm12;
        end
        if (in_valid_reg)
        begin
            ok_reg  <= ok_next;
            nw_reg  <= nw_next;
            dec_reg <= dec_next;
        end
    end

    // Size and sign of an unsigned-offset load/store, from size and opc.
    always_comb
    begin
        ls_shift  = 3'd0;
        ls_access = arfp_pkg::ACC_STORE;
        ls_sext   = 1'b0;
        ls_valid  = 1'b1;
        unique case ({instr_reg[31:30], instr_reg[23:22]})
            4'b00_00: ls_access = arfp_pkg::ACC_STORE;
            4'b00_01: ls_access = arfp_pkg::ACC_LOAD;
            4'b00_10:
            begin
                if (instr_reg[26])
                begin
                    ls_shift  = 3'd4;
                    ls_access = arfp_pkg::ACC_STORE;
                end
                else
                begin
                    ls_access = arfp_pkg::ACC_LOAD;
                    ls_sext   = 1'b1;
                end
            end
            4'b00_11:
            begin
                ls_access = arfp_pkg::ACC_LOAD;
                if (instr_reg[26])
                    ls_shift = 3'd4;
                else
                    ls_sext = 1'b1;
            end
            4'b01_00:
            begin
                ls_shift  = 3'd1;
                ls_access = arfp_pkg::ACC_STORE;
            end
            4'b01_01:
            begin
                ls_shift  = 3'd1;
                ls_access = arfp_pkg::ACC_LOAD;
            end
            4'b01_10, 4'b01_11:
            begin
                ls_shift  = 3'd1;
                ls_access = arfp_pkg::ACC_LOAD;
                ls_sext   = 1'b1;
            end
            4'b10_00:
            begin
                ls_shift  = 3'd2;
                ls_access = arfp_pkg::ACC_STORE;
            end
            4'b10_01:
            begin
                ls_shift  = 3'd2;
                ls_access = arfp_pkg::ACC_LOAD;
            end
            4'b10_10:
            begin
                ls_shift  = 3'd2;
                ls_access = arfp_pkg::ACC_LOAD;
                ls_sext   = 1'b1;
            end
            4'b11_00:
            begin
                ls_shift  = 3'd3;
                ls_access = arfp_pkg::ACC_STORE;
            end
            4'b11_01:
            begin
                ls_shift  = 3'd3;
                ls_access = arfp_pkg::ACC_LOAD;
            end
            default: ls_valid = 1'b0;
        endcase
    end

    // Instruction classification; earlier matches take priority.
    always_comb
    begin
        dec_next = '0;
        dec_next.cls = arfp_pkg::CLS_NONE;
        priority if ((instr_reg & arfp_pkg::ADRP_MASK) == arfp_pkg::ADRP_MATCH)
        begin
            dec_next.cls    = arfp_pkg::CLS_ADRP;
            dec_next.dst    = instr_reg[4:0];
            dec_next.offset = 28'(signed'({instr_reg[23:5], instr_reg[30:29]}));
        end
        else if ((instr_reg & arfp_pkg::B26_MASK) == arfp_pkg::B26_MATCH)
        begin
            dec_next.cls    = arfp_pkg::CLS_B26;
            dec_next.offset = {instr_reg[25:0], 2'b00};
        end
        else if ((instr_reg & arfp_pkg::LDST_MASK) == arfp_pkg::LDST_MATCH)
        begin
            // Unallocated size/opc pairs leave the word unclassified.
            if (ls_valid)
            begin
                dec_next.cls    = arfp_pkg::CLS_IMM12;
                dec_next.dst    = instr_reg[4:0];
                dec_next.src    = instr_reg[9:5];
                dec_next.access = ls_access;
                dec_next.scale  = 5'd1 << ls_shift;
                dec_next.sext   = ls_sext;
                dec_next.fp     = instr_reg[26];
                dec_next.offset = {16'd0, instr_reg[21:10]} << ls_shift;
            end
        end
        else if ((instr_reg & arfp_pkg::ADDI_MASK) == arfp_pkg::ADDI_MATCH)
        begin
            dec_next.cls    = arfp_pkg::CLS_IMM12;
            dec_next.dst    = instr_reg[4:0];
            dec_next.src    = instr_reg[9:5];
            dec_next.access = arfp_pkg::ACC_ADD;
            dec_next.scale  = 5'd1;
            dec_next.offset = {16'd0, instr_reg[21:10]};
        end
        else
        begin
            dec_next.cls = arfp_pkg::CLS_NONE;
        end
    end

    // Displacements. The page delta is kept in 4 KiB units; the range check
    // asks that the signed page delta fit in 21 bits and not reach -2^20.
    assign page_delta = ta_reg[63:12] - ia_reg[63:12];
    assign byte_delta = ta_reg - ia_reg;

    assign adrp_in_range = (page_delta[51:20] == '0) ||
                           ((page_delta[51:20] == '1) && (page_delta[19:0] != '0));
    assign b26_in_range  = (byte_delta[63:27] == '0) ||
                           ((byte_delta[63:27] == '1) && (byte_delta[26:0] != '0));

    // Patch selection; a failed patch returns the word unchanged.
    always_comb
    begin
        ok_next = 1'b0;
        nw_next = instr_reg;
        unique case (arfp_pkg::kind_t'(kind_reg))
            arfp_pkg::KIND_DECODE:
            begin
                ok_next = (dec_next.cls != arfp_pkg::CLS_NONE);
            end
            arfp_pkg::KIND_ADRP:
            begin
                if ((dec_next.cls == arfp_pkg::CLS_ADRP) && adrp_in_range)
                begin
                    ok_next = 1'b1;
                    nw_next = {instr_reg[31], page_delta[1:0], instr_reg[28:24],
                               page_delta[20:2], instr_reg[4:0]};
                end
            end
            arfp_pkg::KIND_B26:
            begin
                if ((dec_next.cls == arfp_pkg::CLS_B26) && b26_in_range)
                begin
                    ok_next = 1'b1;
                    nw_next = {instr_reg[31:26], byte_delta[27:2]};
                end
            end
            arfp_pkg::KIND_IMM12:
            begin
                if (dec_next.cls == arfp_pkg::CLS_IMM12)
                begin
                    ok_next = 1'b1;
                    nw_next = {instr_reg[31:22], imm_reg, instr_reg[9:0]};
                end
            end
            default:
            begin
                ok_next = 1'b0;
            end
        endcase
    end

    // Result ports.
    assign done            = done_reg;
    assign ok              = ok_reg;
    assign new_instruction = nw_reg;
    assign match_class     = dec_reg.cls;
    assign dst_reg         = dec_reg.dst;
    assign src_reg         = dec_reg.src;
    assign offset          = dec_reg.offset;
    assign access_kind     = dec_reg.access;
    assign scale           = dec_reg.scale;
    assign sign_extend     = dec_reg.sext;
    assign is_float        = dec_reg.fp;

endmodule

`default_nettype wire

// ----- dv/arfp_tb_pkg.sv -----
// Scoreboard for the relocation field patcher: expected results and the checks against them.
package arfp_tb_pkg;

    import arfp_pkg::*;

    // Largest page delta an ADRP can encode and largest byte reach of a B26 branch.
    localparam longint PAGE_REACH   = 64'h0000_0000_FFFF_F000;
    localparam longint BRANCH_REACH = 64'h0000_0000_07FF_FFFF;

    // One result beat as the block presents it.
    typedef struct {
        logic               ok;
        logic [31:0]        word;
        class_t             cls;
        logic [4:0]         dst;
        logic [4:0]         src;
        logic signed [27:0] offset;
        logic [1:0]         access;
        logic [4:0]         scale;
        logic               sext;
        logic               fp;
    } patch_result_t;

    class reloc_patch_scoreboard;

        patch_result_t expected_q[$];
        int unsigned   mismatches;
        int unsigned   results_seen;

        function new();
            mismatches   = 0;
            results_seen = 0;
        endfunction

        function int unsigned pending();
            return expected_q.size();
        endfunction

        // Decoded fields of an instruction word, with the word itself passed through.
        function patch_result_t classify_word(logic [31:0] w);
            patch_result_t r;
            logic          valid;
            logic [4:0]    sc;
            logic [1:0]    acc;
            logic          se;

            r.ok     = 1'b0;
            r.word   = w;
            r.cls    = CLS_NONE;
            r.dst    = '0;
            r.src    = '0;
            r.offset = '0;
            r.access = ACC_ADD;
            r.scale  = '0;
            r.sext   = 1'b0;
            r.fp     = 1'b0;

            if ((w & ADRP_MASK) == ADRP_MATCH) begin
                // The page count is immhi:immlo, 21 bits, signed.
                r.cls    = CLS_ADRP;
                r.dst    = w[4:0];
                r.offset = {{7{w[23]}}, w[23:5], w[30:29]};
            end
            else if ((w & B26_MASK) == B26_MATCH) begin
                r.cls    = CLS_B26;
                r.offset = {w[25:0], 2'b00};
            end
            else if ((w & LDST_MASK) == LDST_MATCH) begin
                // Size and opc select the scale, the direction and the sign extension.
                valid = 1'b1;
                sc    = 5'd1;
                acc   = ACC_LOAD;
                se    = 1'b0;
                case ({w[31:30], w[23:22]})
                    4'b0000: acc = ACC_STORE;
                    4'b0001: acc = ACC_LOAD;
                    4'b0010:
                    begin
                        if (w[26]) begin
                            sc  = 5'd16;
                            acc = ACC_STORE;
                        end
                        else begin
                            se = 1'b1;
                        end
                    end
                    4'b0011:
                    begin
                        if (w[26])
                            sc = 5'd16;
                        else
                            se = 1'b1;
                    end
                    4'b0100:
                    begin
                        sc  = 5'd2;
                        acc = ACC_STORE;
                    end
                    4'b0101: sc = 5'd2;
                    4'b0110, 4'b0111:
                    begin
                        sc = 5'd2;
                        se = 1'b1;
                    end
                    4'b1000:
                    begin
                        sc  = 5'd4;
                        acc = ACC_STORE;
                    end
                    4'b1001: sc = 5'd4;
                    4'b1010:
                    begin
                        sc = 5'd4;
                        se = 1'b1;
                    end
                    4'b1100:
                    begin
                        sc  = 5'd8;
                        acc = ACC_STORE;
                    end
                    4'b1101: sc = 5'd8;
                    // The remaining size/opc pairs are unallocated: no class.
                    default: valid = 1'b0;
                endcase
                if (valid) begin
                    r.cls    = CLS_IMM12;
                    r.dst    = w[4:0];
                    r.src    = w[9:5];
                    r.access = acc;
                    r.scale  = sc;
                    r.sext   = se;
                    r.fp     = w[26];
                    r.offset = w[21:10] * 28'(sc);
                end
            end
            else if ((w & ADDI_MASK) == ADDI_MATCH) begin
                r.cls    = CLS_IMM12;
                r.dst    = w[4:0];
                r.src    = w[9:5];
                r.scale  = 5'd1;
                r.offset = {16'd0, w[21:10]};
            end
            return r;
        endfunction

        // Expected result of one beat: the decode plus the requested rewrite.
        function patch_result_t predict_patch(kind_t k, logic [31:0] w, logic [63:0] ia,
                                              logic [63:0] ta, logic [11:0] imm);
            patch_result_t r;
            logic [63:0]   delta;

            r = classify_word(w);
            case (k)
                KIND_DECODE: r.ok = (r.cls != CLS_NONE);
                KIND_ADRP:
                begin
                    if (r.cls == CLS_ADRP) begin
                        delta = {ta[63:12], 12'h000} - {ia[63:12], 12'h000};
                        if ($signed(delta) >= -PAGE_REACH && $signed(delta) <= PAGE_REACH) begin
                            r.word = {w[31], delta[13:12], w[28:24], delta[32:14], w[4:0]};
                            r.ok   = 1'b1;
                        end
                    end
                end
                KIND_B26:
                begin
                    if (r.cls == CLS_B26) begin
                        delta = ta - ia;
                        // Low two bits of the delta are simply dropped.
                        if ($signed(delta) >= -BRANCH_REACH && $signed(delta) <= BRANCH_REACH) begin
                            r.word = {w[31:26], delta[27:2]};
                            r.ok   = 1'b1;
                        end
                    end
                end
                default:
                begin
                    if (r.cls == CLS_IMM12) begin
                        r.word = {w[31:22], imm, w[9:0]};
                        r.ok   = 1'b1;
                    end
                end
            endcase
            return r;
        endfunction

        // An input beat was accepted: queue what it must produce.
        function void note_beat(kind_t k, logic [31:0] w, logic [63:0] ia, logic [63:0] ta,
                                logic [11:0] imm);
            expected_q.push_back(predict_patch(k, w, ia, ta, imm));
        endfunction

        task report_mismatch(string what, logic [63:0] want, logic [63:0] got);
            mismatches++;
            $display("MISMATCH result %0d %s: expected %h, got %h",
                     results_seen, what, want, got);
        endtask

        // A result beat was accepted: compare it with the oldest expectation.
        task check_result(patch_result_t got);
            patch_result_t want;

            results_seen++;
            if (expected_q.size() == 0) begin
                report_mismatch("unexpected result, new_instruction", 64'd0, got.word);
                return;
            end
            want = expected_q.pop_front();
            if (got.ok !== want.ok)
                report_mismatch("ok", want.ok, got.ok);
            if (got.word !== want.word)
                report_mismatch("new_instruction", want.word, got.word);
            if (got.cls !== want.cls)
                report_mismatch("match_class", want.cls, got.cls);
            if (got.dst !== want.dst)
                report_mismatch("dst_reg", want.dst, got.dst);
            if (got.src !== want.src)
                report_mismatch("src_reg", want.src, got.src);
            if (got.offset !== want.offset)
                report_mismatch("offset", want.offset, got.offset);
            if (got.access !== want.access)
                report_mismatch("access_kind", want.access, got.access);
            if (got.scale !== want.scale)
                report_mismatch("scale", want.scale, got.scale);
            if (got.sext !== want.sext)
                report_mismatch("sign_extend", want.sext, got.sext);
            if (got.fp !== want.fp)
                report_mismatch("is_float", want.fp, got.fp);
        endtask

    endclass

endpackage

// ----- dv/tb.sv -----
// Testbench top: drives random and directed beats into the relocation field patcher.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import arfp_pkg::*;
    import arfp_tb_pkg::*;

    localparam realtime     CLK_PERIOD   = 2ns;
    localparam int unsigned RESET_CYCLES = 5;
    localparam int unsigned RANDOM_BEATS = 1780;
    localparam int unsigned DRAIN_CYCLES = 8;
    localparam int unsigned CYCLE_LIMIT  = 200000;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    kind_t              kind = KIND_DECODE;
    logic [31:0]        instruction = '0;
    logic [63:0]        instr_addr = '0;
    logic [63:0]        target_addr = '0;
    logic [11:0]        new_imm12 = '0;
    logic               done;
    logic               ok;
    logic [31:0]        new_instruction;
    logic [1:0]         match_class;
    logic [4:0]         dst_reg;
    logic [4:0]         src_reg;
    logic signed [27:0] offset;
    logic [1:0]         access_kind;
    logic [4:0]         scale;
    logic               sign_extend;
    logic               is_float;

    int unsigned cycle_count = 0;

    reloc_patch_scoreboard sb = new();

    arm64_reloc_field_patcher DUT (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .kind            (kind),
        .instruction     (instruction),
        .instr_addr      (instr_addr),
        .target_addr     (target_addr),
        .new_imm12       (new_imm12),
        .done            (done),
        .ok              (ok),
        .new_instruction (new_instruction),
        .match_class     (match_class),
        .dst_reg         (dst_reg),
        .src_reg         (src_reg),
        .offset          (offset),
        .access_kind     (access_kind),
        .scale           (scale),
        .sign_extend     (sign_extend),
        .is_float        (is_float)
    );

    // Clock.
    always #(CLK_PERIOD / 2) clk = ~clk;

    // Cycle counter and the timeout it drives.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
    end

    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("Regression FAIL");
        $finish;
    end

    // Every cycle with done high carries one result beat.
    always @(posedge clk)
    begin : watch_results
        patch_result_t seen;
        if (rst_n && done) begin
            seen.ok     = ok;
            seen.word   = new_instruction;
            seen.cls    = class_t'(match_class);
            seen.dst    = dst_reg;
            seen.src    = src_reg;
            seen.offset = offset;
            seen.access = access_kind;
            seen.scale  = scale;
            seen.sext   = sign_extend;
            seen.fp     = is_float;
            sb.check_result(seen);
        end
    end

    // Present one beat and hold it until the block takes it.
    task automatic send_beat(kind_t k, logic [31:0] w, logic [63:0] ia, logic [63:0] ta,
                             logic [11:0] imm);
        start       <= 1'b1;
        kind        <= k;
        instruction <= w;
        instr_addr  <= ia;
        target_addr <= ta;
        new_imm12   <= imm;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        sb.note_beat(k, w, ia, ta, imm);
    endtask

    // Sender gap; start is held low for the given number of cycles.
    task automatic pause_sender(int unsigned cycles);
        start <= 1'b0;
        repeat (cycles)
            @(posedge clk);
    endtask

    // Hold off the sender until every expected result has come back.
    task automatic wait_for_results();
        start <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        int unsigned sent;
        int unsigned burst;
        int unsigned shape;
        kind_t       k;
        logic [31:0] w;
        logic [31:0] r;
        logic [63:0] ia;
        logic [63:0] d;
        longint      reach;
        int unsigned spread;

        repeat (RESET_CYCLES)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed beats: field extremes, each class, unallocated sizes and the range edges.
        send_beat(KIND_DECODE, 32'h0000_0000, 64'd0, 64'd0, 12'h000);
        send_beat(KIND_DECODE, 32'hFFFF_FFFF, '1, '1, 12'hFFF);
        send_beat(KIND_DECODE, 32'hF0FF_FFFF, 64'd0, 64'd0, 12'h000);
        send_beat(KIND_DECODE, 32'h97FF_FFFF, 64'd0, 64'd0, 12'h000);
        send_beat(KIND_DECODE, 32'hF97F_FFFF, 64'd0, 64'd0, 12'h000);
        send_beat(KIND_DECODE, 32'h3D80_0000, 64'd0, 64'd0, 12'h000);
        send_beat(KIND_DECODE, 32'h3DFF_FFFF, 64'd0, 64'd0, 12'h000);
        send_beat(KIND_DECODE, 32'h3980_0421, 64'd0, 64'd0, 12'h000);
        send_beat(KIND_DECODE, 32'h79C0_0000, 64'd0, 64'd0, 12'h000);
        send_beat(KIND_DECODE, 32'hB980_0000, 64'd0, 64'd0, 12'h000);
        // Unallocated load/store sizes decode to no class.
        send_beat(KIND_DECODE, 32'hB9C0_0000, 64'd0, 64'd0, 12'h000);
        send_beat(KIND_DECODE, 32'hF980_0000, 64'd0, 64'd0, 12'h000);
        send_beat(KIND_IMM12,  32'hF9C0_0000, 64'd0, 64'd0, 12'h123);
        // Shifted ADD immediate is not an imm12 form; plain ADD with the largest imm is.
        send_beat(KIND_DECODE, 32'h9140_0000, 64'd0, 64'd0, 12'h000);
        send_beat(KIND_DECODE, 32'h913F_FFFF, 64'd0, 64'd0, 12'h000);
        // ADRP page delta at and just past both ends of its reach.
        send_beat(KIND_ADRP, 32'h9000_0000, 64'h0000_0000_0000_0FFF,
                  64'h0000_0000_FFFF_FFFF, 12'h000);
        send_beat(KIND_ADRP, 32'h9000_0000, 64'h0000_0000_0000_0FFF,
                  64'h0000_0001_0000_0000, 12'h000);
        send_beat(KIND_ADRP, 32'hF0FF_FFFF, 64'h0000_0000_FFFF_F000, 64'd0, 12'h000);
        send_beat(KIND_ADRP, 32'hF0FF_FFFF, 64'h0000_0001_0000_0FFF, 64'd0, 12'h000);
        // Branch delta at and just past both ends of its reach, and across address wrap.
        send_beat(KIND_B26, 32'h1400_0000, 64'd0, 64'h0000_0000_07FF_FFFF, 12'h000);
        send_beat(KIND_B26, 32'h9400_0000, 64'd0, 64'h0000_0000_0800_0000, 12'h000);
        send_beat(KIND_B26, 32'h17FF_FFFF, 64'h0000_0000_07FF_FFFF, 64'd0, 12'h000);
        send_beat(KIND_B26, 32'h9400_0000, 64'h0000_0000_0800_0000, 64'd0, 12'h000);
        send_beat(KIND_B26, 32'h1400_0000, 64'hFFFF_FFFF_FFFF_FFFC, 64'd4, 12'h000);
        // Set imm12 on a load, then each patch kind on a word of another class.
        send_beat(KIND_IMM12, 32'hF940_0000, 64'd0, 64'd0, 12'hFFF);
        send_beat(KIND_IMM12, 32'h9000_0000, 64'd0, 64'd0, 12'hABC);
        send_beat(KIND_ADRP,  32'h1400_0000, 64'd0, 64'h1000, 12'h000);
        send_beat(KIND_B26,   32'h0000_0000, 64'd0, 64'h10, 12'h000);
        wait_for_results();

        // Random beats, sent in bursts of random length with random gaps between them.
        sent = 0;
        while (sent < RANDOM_BEATS) begin
            burst = $urandom_range(1, 48);
            repeat (burst) begin
                w     = $urandom;
                shape = $urandom_range(0, 9);
                case (shape)
                    2, 3:
                    begin
                        w = (w & ~ADRP_MASK) | ADRP_MATCH;
                        k = KIND_ADRP;
                    end
                    4, 5:
                    begin
                        w = (w & ~B26_MASK) | B26_MATCH;
                        k = KIND_B26;
                    end
                    6, 7:
                    begin
                        w = (w & ~LDST_MASK) | LDST_MATCH;
                        k = KIND_IMM12;
                    end
                    8, 9:
                    begin
                        w = (w & ~ADDI_MASK) | ADDI_MATCH;
                        k = KIND_IMM12;
                    end
                    default: k = kind_t'($urandom_range(0, 3));
                endcase
                // One word in four gets its operation drawn anew at random.
                if ($urandom_range(0, 3) == 0)
                    k = kind_t'($urandom_range(0, 3));

                // Target address: near the reach limit, a sign-extended 32-bit offset, modest, or anywhere.
                ia = {$urandom, $urandom};
                if (k == KIND_ADRP) begin
                    reach  = PAGE_REACH;
                    spread = 32'h3000;
                end
                else begin
                    reach  = BRANCH_REACH;
                    spread = 16;
                end
                r = $urandom;
                case ($urandom_range(0, 3))
                    0: d = 64'(reach) - 64'(spread) + 64'($urandom_range(0, 2 * spread));
                    1: d = {{32{r[31]}}, r};
                    2: d = {$urandom, $urandom};
                    default: d = 64'($urandom_range(0, 32'h0020_0000));
                endcase
                if ($urandom_range(0, 1))
                    d = -d;

                send_beat(k, w, ia, ia + d, 12'($urandom));
                sent++;
            end
            if ($urandom_range(0, 24) == 0)
                wait_for_results();
            else if ($urandom_range(0, 3) != 0)
                pause_sender($urandom_range(1, 6));
        end

        // Let everything drain, then wait out DRAIN_CYCLES for stray results.
        wait_for_results();
        repeat (DRAIN_CYCLES)
            @(posedge clk);
        if (sb.pending() != 0)
            sb.report_mismatch("results never arrived, count", 64'd0, 64'(sb.pending()));

        if (sb.mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// ----- sim.f -----
hdl/arfp_pkg.sv
hdl/arm64_reloc_field_patcher.sv
dv/arfp_tb_pkg.sv
dv/tb.sv
